### src/c3z_pkg.sv
`timescale 1ns / 1ps
package c3z_pkg;

  localparam int FW_BITS       = 11;
  localparam int FH_BITS       = 13;
  localparam int ROW_BITS      = 12;
  localparam int VALUE_BITS    = 20;
  localparam int CFG_IDX_BITS  = 3;
  localparam int OUT_DEPTH     = 8;
  localparam int OUT_CNT_BITS  = $clog2(OUT_DEPTH + 1);

  localparam logic [FH_BITS-1:0] HEIGHT_LIMIT = 13'd4096;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_KERNEL_TOP    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_KERNEL_MIDDLE = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_KERNEL_BOTTOM = 3'd4;

  typedef struct packed {
    logic emit;
    logic top_ok;
    logic bot_ok;
    logic left_ok;
    logic right_ok;
    logic last;
  } c3z_flags_t;

  localparam int FLAGS_BITS = $bits(c3z_flags_t);

endpackage

### src/conv3x3_zero_pad_filter_unit.sv
`timescale 1ns / 1ps
// Streaming 3x3 correlation filter with zero padding at the frame edges.
// Pixels enter in raster order at one per clock while in_ready is high, and each
// filtered value leaves one row plus one pixel after its centre pixel; drain
// requests after the last pixel flush the final row. Results pass through the
// command queue and the s2, s3, s4 and result registers. After reset the line
// store is cleared before the first request is taken. A frame width write, or
// an output column left beyond a newly narrowed width, holds the input while
// the drain column is recomputed by a one-bit-per-clock remainder unit.
module conv3x3_zero_pad_filter_unit #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 8,
  parameter int COEF_BITS  = 8
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          in_valid,
  output logic                                          in_ready,
  input  logic                                          in_op,
  input  logic [PIXEL_BITS-1:0]                         in_pixel,
  output logic                                          out_valid,
  input  logic                                          out_ready,
  output logic signed [c3z_pkg::VALUE_BITS-1:0]         out_value,
  output logic                                          out_frame_last,
  input  logic                                          cfg_valid,
  output logic                                          cfg_ready,
  input  logic [c3z_pkg::CFG_IDX_BITS-1:0]              cfg_index,
  input  logic [((3*COEF_BITS > 13) ? 3*COEF_BITS : 13)-1:0] cfg_data
);
  import c3z_pkg::*;

  localparam int CB = $clog2(MAX_WIDTH);
  localparam int KB = 3 * COEF_BITS;
  localparam int QW = CB + PIXEL_BITS + FLAGS_BITS;
  localparam int OW = VALUE_BITS + 1;
  localparam int CQ_DEPTH = 4;
  localparam int CQW = $clog2(CQ_DEPTH + 1);

  logic [FW_BITS-1:0] fw_r;
  logic [FH_BITS-1:0] fh_r;
  logic [KB-1:0]      kt_r, km_r, kb_r;
  logic               cfg_wr, width_wr, clearing;

  logic               fc_valid, fc_ready;
  logic [CB-1:0]      fc_col, bq_col;
  logic [PIXEL_BITS-1:0] fc_px, bq_px;
  c3z_flags_t         fc_flags, bq_flags;
  logic               bq_valid, bq_ready;
  logic [QW-1:0]      bq_data;
  logic [CQW-1:0]     cq_count;

  logic               res_valid, res_last, obuf_ready;
  logic signed [VALUE_BITS-1:0] res_value;
  logic [OUT_CNT_BITS-1:0] obuf_count;
  logic [OW-1:0]      obuf_data;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign width_wr  = cfg_wr && (cfg_index == REG_FRAME_WIDTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= FW_BITS'(640);
      fh_r <= FH_BITS'(480);
      kt_r <= '0;
      km_r <= KB'(1) << COEF_BITS;
      kb_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_FRAME_WIDTH:   fw_r <= cfg_data[FW_BITS-1:0];
        REG_FRAME_HEIGHT:  fh_r <= cfg_data[FH_BITS-1:0];
        REG_KERNEL_TOP:    kt_r <= cfg_data[KB-1:0];
        REG_KERNEL_MIDDLE: km_r <= cfg_data[KB-1:0];
        REG_KERNEL_BOTTOM: kb_r <= cfg_data[KB-1:0];
        default: ;
      endcase
    end
  end

  c3z_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .frame_width  (fw_r),
    .frame_height (fh_r),
    .width_wr     (width_wr),
    .hold         (clearing),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_op        (in_op),
    .in_pixel     (in_pixel),
    .cmd_valid    (fc_valid),
    .cmd_ready    (fc_ready),
    .cmd_col      (fc_col),
    .cmd_px       (fc_px),
    .cmd_flags    (fc_flags)
  );

  c3z_queue #(
    .DEPTH (CQ_DEPTH),
    .WIDTH (QW)
  ) u_cmd_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fc_valid),
    .wr_ready (fc_ready),
    .wr_data  ({fc_col, fc_px, fc_flags}),
    .rd_valid (bq_valid),
    .rd_ready (bq_ready),
    .rd_data  (bq_data),
    .count    (cq_count)
  );

  assign {bq_col, bq_px, bq_flags} = bq_data;

  c3z_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS),
    .COEF_BITS  (COEF_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .kernel_top (kt_r),
    .kernel_mid (km_r),
    .kernel_bot (kb_r),
    .q_valid    (bq_valid),
    .q_ready    (bq_ready),
    .q_col      (bq_col),
    .q_px       (bq_px),
    .q_flags    (bq_flags),
    .obuf_count (obuf_count),
    .res_valid  (res_valid),
    .res_value  (res_value),
    .res_last   (res_last),
    .clearing   (clearing)
  );

  c3z_queue #(
    .DEPTH (OUT_DEPTH),
    .WIDTH (OW)
  ) u_out_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (res_valid),
    .wr_ready (obuf_ready),
    .wr_data  ({res_value, res_last}),
    .rd_valid (out_valid),
    .rd_ready (out_ready),
    .rd_data  (obuf_data),
    .count    (obuf_count)
  );

  assign out_value      = obuf_data[OW-1:1];
  assign out_frame_last = obuf_data[0];

`ifndef ASSERT_OFF
  a_out_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> obuf_ready)
    else $error("result arrived at a full output buffer");

  a_clear_hold: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !in_ready && !bq_ready)
    else $error("request taken during line store clear");

  a_cmd_room: assert property (@(posedge clk) disable iff (!rst_n)
    fc_valid |-> fc_ready)
    else $error("front issued a command into a full queue");

  a_cmd_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (cq_count == CQW'(CQ_DEPTH)) |-> !in_ready)
    else $error("request taken while the command queue is full");
`endif

endmodule

### src/c3z_queue.sv
`timescale 1ns / 1ps
module c3z_queue #(
  parameter int DEPTH = 4,
  parameter int WIDTH = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         wr_valid,
  output logic                         wr_ready,
  input  logic [WIDTH-1:0]             wr_data,
  output logic                         rd_valid,
  input  logic                         rd_ready,
  output logic [WIDTH-1:0]             rd_data,
  output logic [$clog2(DEPTH+1)-1:0]   count
);
  localparam int AB = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NB = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AB-1:0]    wp_r, wp_nxt, rp_r, rp_nxt;
  logic [NB-1:0]    cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign wr_ready = (cnt_r != NB'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem[rp_r];
  assign count    = cnt_r;
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_wr) begin
      wp_nxt = (wp_r == AB'(DEPTH - 1)) ? '0 : wp_r + AB'(1);
    end
    if (do_rd) begin
      rp_nxt = (rp_r == AB'(DEPTH - 1)) ? '0 : rp_r + AB'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + NB'(1);
    end else if (!do_wr && do_rd) begin
      cnt_nxt = cnt_r - NB'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wp_r] <= wr_data;
    end
  end

endmodule

### src/c3z_front.sv
`timescale 1ns / 1ps
module c3z_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [c3z_pkg::FW_BITS-1:0]       frame_width,
  input  logic [c3z_pkg::FH_BITS-1:0]       frame_height,
  input  logic                              width_wr,
  input  logic                              hold,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_op,
  input  logic [PIXEL_BITS-1:0]             in_pixel,
  output logic                              cmd_valid,
  input  logic                              cmd_ready,
  output logic [$clog2(MAX_WIDTH)-1:0]      cmd_col,
  output logic [PIXEL_BITS-1:0]             cmd_px,
  output c3z_pkg::c3z_flags_t               cmd_flags
);
  import c3z_pkg::*;

  localparam int CB = $clog2(MAX_WIDTH);
  localparam int XB = ((CB > FW_BITS) ? CB : FW_BITS) + 2;
  localparam int PB = $clog2(MAX_WIDTH + 2);
  localparam int SB = $clog2(2 * MAX_WIDTH + 1);
  localparam int NB = $clog2(SB + 1);

  logic [ROW_BITS-1:0] in_row_r, in_row_nxt, out_row_r, out_row_nxt;
  logic [CB-1:0]       in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [CB-1:0]       dcol_r, dcol_nxt;
  logic [PB-1:0]       pend_r, pend_nxt;
  logic                drain_r, drain_nxt;
  logic                busy_r, busy_nxt, ld_r, ld_nxt;
  logic [XB-1:0]       rem_r, rem_nxt;
  logic [SB-1:0]       sacc_r, sacc_nxt;
  logic [NB-1:0]       cnt_r, cnt_nxt;

  logic [XB-1:0]       w, pend1, step, step_red;
  logic [FH_BITS-1:0]  h;
  logic                acc, is_pix, drain_ok, do_cmd, emit, fresh;
  logic [PB-1:0]       b_pend;
  logic [ROW_BITS-1:0] b_orow;
  logic [CB-1:0]       b_ocol, b_dcol, dcol_inc;
  logic                ocol_end, orow_end, last, odd, trigger;

  always_comb begin
    if (frame_width == '0) begin
      w = XB'(1);
    end else if (XB'(frame_width) > XB'(MAX_WIDTH)) begin
      w = XB'(MAX_WIDTH);
    end else begin
      w = XB'(frame_width);
    end
    if (frame_height == '0) begin
      h = FH_BITS'(1);
    end else if (frame_height > HEIGHT_LIMIT) begin
      h = HEIGHT_LIMIT;
    end else begin
      h = frame_height;
    end
  end

  assign in_ready = !busy_r && !hold && cmd_ready;
  assign acc      = in_valid && in_ready;
  assign is_pix   = (in_op == OP_PIXEL);
  assign drain_ok = (pend_r != '0) && (in_row_r == '0) && (in_col_r == '0);
  assign do_cmd   = acc && (is_pix || drain_ok);
  assign fresh    = is_pix && drain_r;

  assign b_pend = fresh ? '0 : pend_r;
  assign b_orow = fresh ? '0 : out_row_r;
  assign b_ocol = fresh ? '0 : out_col_r;
  assign b_dcol = fresh ? '0 : dcol_r;

  assign pend1    = XB'(b_pend) + XB'(1);
  assign emit     = pend1 > (w + XB'(1));
  assign dcol_inc = ((XB'(b_dcol) + XB'(1)) >= w) ? '0 : b_dcol + CB'(1);
  assign ocol_end = (XB'(b_ocol) + XB'(1)) >= w;
  assign orow_end = (FH_BITS'(b_orow) + FH_BITS'(1)) >= h;
  assign odd      = (XB'(b_ocol) + XB'(1)) > w;
  assign last     = ocol_end && orow_end;

  assign cmd_valid          = do_cmd;
  assign cmd_col            = is_pix ? in_col_r : dcol_r;
  assign cmd_px             = is_pix ? in_pixel : '0;
  assign cmd_flags.emit     = emit;
  assign cmd_flags.top_ok   = (b_orow != '0);
  assign cmd_flags.bot_ok   = !orow_end;
  assign cmd_flags.left_ok  = (b_ocol != '0);
  assign cmd_flags.right_ok = !ocol_end;
  assign cmd_flags.last     = last;

  assign trigger = width_wr || (do_cmd && emit && odd && !(!is_pix && last));

  assign step     = {rem_r[XB-2:0], sacc_r[SB-1]};
  assign step_red = (step >= w) ? step - w : step;

  always_comb begin
    in_row_nxt  = in_row_r;
    in_col_nxt  = in_col_r;
    out_row_nxt = out_row_r;
    out_col_nxt = out_col_r;
    pend_nxt    = pend_r;
    drain_nxt   = drain_r;
    dcol_nxt    = dcol_r;
    busy_nxt    = busy_r;
    ld_nxt      = ld_r;
    rem_nxt     = rem_r;
    sacc_nxt    = sacc_r;
    cnt_nxt     = cnt_r;
    if (do_cmd) begin
      if (is_pix) begin
        if ((XB'(in_col_r) + XB'(1)) >= w) begin
          in_col_nxt = '0;
          in_row_nxt = ((FH_BITS'(in_row_r) + FH_BITS'(1)) >= h) ? '0
                                                                  : in_row_r + ROW_BITS'(1);
        end else begin
          in_col_nxt = in_col_r + CB'(1);
        end
      end
      drain_nxt   = !is_pix;
      dcol_nxt    = dcol_inc;
      pend_nxt    = pend1[PB-1:0];
      out_row_nxt = b_orow;
      out_col_nxt = b_ocol;
      if (emit) begin
        pend_nxt = b_pend;
        if (ocol_end) begin
          out_col_nxt = '0;
          out_row_nxt = orow_end ? '0 : b_orow + ROW_BITS'(1);
        end else begin
          out_col_nxt = b_ocol + CB'(1);
        end
        if (!is_pix && last) begin
          pend_nxt  = '0;
          drain_nxt = 1'b0;
          dcol_nxt  = '0;
        end
      end
    end
    if (trigger) begin
      busy_nxt = 1'b1;
      ld_nxt   = 1'b1;
    end else if (ld_r) begin
      ld_nxt   = 1'b0;
      sacc_nxt = SB'(out_col_r) + SB'(pend_r);
      rem_nxt  = '0;
      cnt_nxt  = NB'(SB);
    end else if (busy_r) begin
      rem_nxt  = step_red;
      sacc_nxt = sacc_r << 1;
      cnt_nxt  = cnt_r - NB'(1);
      if (cnt_r == NB'(1)) begin
        busy_nxt = 1'b0;
        dcol_nxt = step_red[CB-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_row_r  <= '0;
      in_col_r  <= '0;
      out_row_r <= '0;
      out_col_r <= '0;
      pend_r    <= '0;
      drain_r   <= 1'b0;
      dcol_r    <= '0;
      busy_r    <= 1'b0;
      ld_r      <= 1'b0;
      cnt_r     <= '0;
    end else begin
      in_row_r  <= in_row_nxt;
      in_col_r  <= in_col_nxt;
      out_row_r <= out_row_nxt;
      out_col_r <= out_col_nxt;
      pend_r    <= pend_nxt;
      drain_r   <= drain_nxt;
      dcol_r    <= dcol_nxt;
      busy_r    <= busy_nxt;
      ld_r      <= ld_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    sacc_r <= sacc_nxt;
  end

endmodule

### src/c3z_back.sv
`timescale 1ns / 1ps
module c3z_back #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 8,
  parameter int COEF_BITS  = 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic [3*COEF_BITS-1:0]                kernel_top,
  input  logic [3*COEF_BITS-1:0]                kernel_mid,
  input  logic [3*COEF_BITS-1:0]                kernel_bot,
  input  logic                                  q_valid,
  output logic                                  q_ready,
  input  logic [$clog2(MAX_WIDTH)-1:0]          q_col,
  input  logic [PIXEL_BITS-1:0]                 q_px,
  input  c3z_pkg::c3z_flags_t                   q_flags,
  input  logic [c3z_pkg::OUT_CNT_BITS-1:0]      obuf_count,
  output logic                                  res_valid,
  output logic signed [c3z_pkg::VALUE_BITS-1:0] res_value,
  output logic                                  res_last,
  output logic                                  clearing
);
  import c3z_pkg::*;

  localparam int CB  = $clog2(MAX_WIDTH);
  localparam int P   = PIXEL_BITS;
  localparam int PRW = PIXEL_BITS + COEF_BITS + 1;
  localparam int RSW = PRW + 2;
  localparam int SMW = PRW + 4;

  logic [2*P-1:0]  mem [MAX_WIDTH];
  logic [2*P-1:0]  rd_r, line, wl_data_r;
  logic [CB-1:0]   wl_col_r, clr_addr_r, s2_col_r;
  logic            wl_v_r, clr_r, s2_v_r, s3_v_r, s4_v_r, res_v_r;
  logic [P-1:0]    s2_px_r;
  c3z_flags_t      s2_f_r;
  logic            s3_last_r, s4_last_r, res_last_r;
  logic [P-1:0]    win_r [3][3];
  logic [P-1:0]    nwin [3][3];
  logic [P-1:0]    top_px, mid_px;
  logic signed [PRW-1:0] prod [3][3];
  logic signed [PRW-1:0] prod_r [3][3];
  logic signed [RSW-1:0] rs_r [3];
  logic signed [SMW-1:0] sum;
  logic signed [VALUE_BITS-1:0] res_val_r;
  logic [3*COEF_BITS-1:0] krow [3];
  logic [OUT_CNT_BITS+2:0] need;
  logic            credit, pop;

  assign krow[0] = kernel_top;
  assign krow[1] = kernel_mid;
  assign krow[2] = kernel_bot;

  assign need = (OUT_CNT_BITS+3)'(obuf_count) + (OUT_CNT_BITS+3)'(s2_v_r && s2_f_r.emit)
              + (OUT_CNT_BITS+3)'(s3_v_r) + (OUT_CNT_BITS+3)'(s4_v_r)
              + (OUT_CNT_BITS+3)'(res_v_r) + (OUT_CNT_BITS+3)'(1);
  assign credit   = need <= (OUT_CNT_BITS+3)'(OUT_DEPTH);
  assign pop      = q_valid && !clr_r && (!q_flags.emit || credit);
  assign q_ready  = !clr_r && (!q_flags.emit || credit);
  assign clearing = clr_r;

  assign line   = (wl_v_r && (wl_col_r == s2_col_r)) ? wl_data_r : rd_r;
  assign top_px = line[2*P-1:P];
  assign mid_px = line[P-1:0];

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      for (int r = 0; r < 3; r++) begin
        nwin[k][r] = win_r[k+1][r];
      end
    end
    nwin[2][0] = top_px;
    nwin[2][1] = mid_px;
    nwin[2][2] = s2_px_r;
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        if ((r == 0 && !s2_f_r.top_ok) || (r == 2 && !s2_f_r.bot_ok) ||
            (k == 0 && !s2_f_r.left_ok) || (k == 2 && !s2_f_r.right_ok)) begin
          prod[k][r] = '0;
        end else begin
          prod[k][r] = PRW'($signed({1'b0, nwin[k][r]}) *
                            $signed(krow[r][k*COEF_BITS +: COEF_BITS]));
        end
      end
    end
  end

  assign sum = SMW'(rs_r[0]) + SMW'(rs_r[1]) + SMW'(rs_r[2]);

  always_ff @(posedge clk) begin
    if (clr_r) begin
      mem[clr_addr_r] <= '0;
    end else if (s2_v_r) begin
      mem[s2_col_r] <= {mid_px, s2_px_r};
    end
    if (pop) begin
      rd_r <= mem[q_col];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
      wl_v_r     <= 1'b0;
      s2_v_r     <= 1'b0;
      s3_v_r     <= 1'b0;
      s4_v_r     <= 1'b0;
      res_v_r    <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        for (int r = 0; r < 3; r++) begin
          win_r[k][r] <= '0;
        end
      end
    end else begin
      if (clr_r) begin
        clr_addr_r <= clr_addr_r + CB'(1);
        if (clr_addr_r == CB'(MAX_WIDTH - 1)) begin
          clr_r <= 1'b0;
        end
      end
      wl_v_r  <= s2_v_r && !clr_r;
      s2_v_r  <= pop;
      s3_v_r  <= s2_v_r && s2_f_r.emit;
      s4_v_r  <= s3_v_r;
      res_v_r <= s4_v_r;
      if (s2_v_r) begin
        win_r <= nwin;
      end
    end
  end

  always_ff @(posedge clk) begin
    wl_col_r   <= s2_col_r;
    wl_data_r  <= {mid_px, s2_px_r};
    s2_col_r   <= q_col;
    s2_px_r    <= q_px;
    s2_f_r     <= q_flags;
    prod_r     <= prod;
    s3_last_r  <= s2_f_r.last;
    for (int r = 0; r < 3; r++) begin
      rs_r[r] <= RSW'(prod_r[0][r]) + RSW'(prod_r[1][r]) + RSW'(prod_r[2][r]);
    end
    s4_last_r  <= s3_last_r;
    res_val_r  <= VALUE_BITS'(sum);
    res_last_r <= s4_last_r;
  end

  assign res_valid = res_v_r;
  assign res_value = res_val_r;
  assign res_last  = res_last_r;

endmodule
